// ===== rtl/core/ipps_pkg.sv =====
`default_nettype none

package ipps_pkg;

   // Geometry of the flash and of the verified image head.
   localparam int PAGE_SHIFT     = 7;
   localparam int FLASH_PAGE_LEN = 1 << PAGE_SHIFT;
   localparam int VERIFY_WORDS   = 64;
   localparam int HEAD_BYTES     = 2 * VERIFY_WORDS;
   localparam int HEAD_AW        = $clog2(HEAD_BYTES);
   localparam int VI_W           = $clog2(VERIFY_WORDS + 1);

   localparam int ADDR_W = 17;
   localparam int LEN_W  = 16;
   localparam int BYTE_W = 8;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // Request kinds.
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_IMAGE = 2'd1;
   localparam logic [1:0] CMD_REPLY = 2'd2;

   // Register indexes.
   localparam logic [1:0] REG_BOOT_START = 2'd0;
   localparam logic [1:0] REG_BOOT_SIZE  = 2'd1;
   localparam logic [1:0] REG_PW_PAUSE   = 2'd2;

   // Serial programming instructions.
   localparam logic [7:0] OP_ERASE   = 8'hAC;
   localparam logic [7:0] OP_LOAD_LO = 8'h40;
   localparam logic [7:0] OP_LOAD_HI = 8'h48;
   localparam logic [7:0] OP_WRITE   = 8'h4C;
   localparam logic [7:0] OP_READ_LO = 8'h20;
   localparam logic [7:0] OP_READ_HI = 8'h28;
   localparam logic [7:0] ERASE_B1   = 8'h80;
   localparam logic [7:0] PAD_BYTE   = 8'hFF;

   localparam logic [1:0] WAIT_NONE  = 2'd0;
   localparam logic [1:0] WAIT_ERASE = 2'd1;
   localparam logic [1:0] WAIT_PAGE  = 2'd2;

   localparam logic [1:0] ST_BUSY = 2'd0;
   localparam logic [1:0] ST_PASS = 2'd1;
   localparam logic [1:0] ST_FAIL = 2'd2;

   // Result slots of one job, issued in ascending order.
   localparam int NSLOTS = 7;
   localparam int SLOT_W = 3;
   localparam logic [SLOT_W-1:0] SLOT_ERASE   = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_PW_PRE  = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_LOAD_LO = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_LOAD_HI = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_PW_END  = 3'd4;
   localparam logic [SLOT_W-1:0] SLOT_READ    = 3'd5;
   localparam logic [SLOT_W-1:0] SLOT_STATUS  = 3'd6;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_LOAD   = 4'b0010,
      PH_VERIFY = 4'b0100,
      PH_DONE   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [NSLOTS-1:0] mask;
      logic [ADDR_W-1:0] pw_pre_addr;
      logic [ADDR_W-1:0] load_addr;
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      logic [ADDR_W-1:0] pw_end_addr;
      logic              read_high;
      logic [ADDR_W-1:0] read_addr;
      logic [1:0]        status;
   } job_type;

   typedef struct packed {
      logic              has_command;
      logic [BYTE_W-1:0] cmd_byte0;
      logic [BYTE_W-1:0] cmd_byte1;
      logic [BYTE_W-1:0] cmd_byte2;
      logic [BYTE_W-1:0] cmd_byte3;
      logic              expects_reply;
      logic [1:0]        wait_code;
      logic [1:0]        run_status;
      logic              last_of_run;
   } rsp_type;

   // First word address of the page holding addr.
   function automatic logic [ADDR_W-1:0] page_of(input logic [ADDR_W-1:0] addr);
      page_of = addr & ({ADDR_W{1'b1}} << PAGE_SHIFT);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ipps_front.sv =====
`default_nettype none

module ipps_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_accept,
   input  logic [1:0]                   req_cmd,
   input  logic [ipps_pkg::LEN_W-1:0]   req_image_length,
   input  logic [ipps_pkg::BYTE_W-1:0]  req_payload_byte,
   input  logic [ipps_pkg::ADDR_W-1:0]  cfg_boot_start_word,
   input  logic [ipps_pkg::LEN_W-1:0]   cfg_boot_size_bytes,
   output logic                         job_push,
   output ipps_pkg::job_type            job
);

   ipps_pkg::phase_type                phase_ff, phase_in;
   logic [ipps_pkg::ADDR_W-1:0]        wa_ff, wa_in;
   logic [ipps_pkg::ADDR_W-1:0]        open_ff, open_in;
   logic [ipps_pkg::LEN_W-1:0]         seen_ff, seen_in;
   logic [ipps_pkg::LEN_W-1:0]         img_ff, img_in;
   logic [ipps_pkg::BYTE_W-1:0]        held_ff, held_in;
   logic [ipps_pkg::VI_W-1:0]          vi_ff, vi_in;
   logic                               vh_ff, vh_in;
   logic                               lo_ok_ff, lo_ok_in;

   logic [ipps_pkg::BYTE_W-1:0]        head_mem_ff [ipps_pkg::HEAD_BYTES];
   logic [ipps_pkg::BYTE_W-1:0]        head_q_ff;
   logic                               head_we;
   logic [ipps_pkg::HEAD_AW-1:0]       head_waddr;
   logic [ipps_pkg::HEAD_AW-1:0]       head_raddr;

   logic [ipps_pkg::LEN_W:0]           pos_inc;
   logic                               last;
   logic [ipps_pkg::VI_W-1:0]          vi_inc;
   logic [ipps_pkg::BYTE_W-1:0]        expected;
   logic [ipps_pkg::ADDR_W-1:0]        cur_page;

   assign pos_inc  = {1'b0, seen_ff} + {{ipps_pkg::LEN_W{1'b0}}, 1'b1};
   assign last     = pos_inc >= {1'b0, img_ff};
   assign vi_inc   = vi_ff + ipps_pkg::VI_W'(1);
   assign cur_page = ipps_pkg::page_of(wa_ff);

   // The head byte for the current verify position is prefetched from vi_in,
   // and vh_in, so head_q_ff always matches the present verify_index and half.
   assign expected = (ipps_pkg::LEN_W'({vi_ff, vh_ff}) < img_ff) ? head_q_ff
                                                                 : ipps_pkg::PAD_BYTE;
   assign head_raddr = ipps_pkg::HEAD_AW'({vi_in, vh_in});
   assign head_waddr = seen_ff[ipps_pkg::HEAD_AW-1:0];

   always_comb begin
      phase_in = phase_ff;
      wa_in    = wa_ff;
      open_in  = open_ff;
      seen_in  = seen_ff;
      img_in   = img_ff;
      held_in  = held_ff;
      vi_in    = vi_ff;
      vh_in    = vh_ff;
      lo_ok_in = lo_ok_ff;
      job      = '0;
      job_push = 1'b0;
      head_we  = 1'b0;
      if (req_accept) begin
         case (req_cmd)
            ipps_pkg::CMD_START: begin
               job_push = 1'b1;
               if (req_image_length > cfg_boot_size_bytes) begin
                  job.mask[ipps_pkg::SLOT_STATUS] = 1'b1;
                  job.status = ipps_pkg::ST_FAIL;
                  phase_in = ipps_pkg::PH_DONE;
               end else begin
                  job.mask[ipps_pkg::SLOT_ERASE] = 1'b1;
                  img_in   = req_image_length;
                  seen_in  = '0;
                  held_in  = '0;
                  wa_in    = cfg_boot_start_word;
                  open_in  = ipps_pkg::page_of(cfg_boot_start_word);
                  phase_in = ipps_pkg::PH_LOAD;
                  if (req_image_length == '0) begin
                     job.mask[ipps_pkg::SLOT_PW_END] = 1'b1;
                     job.mask[ipps_pkg::SLOT_READ]   = 1'b1;
                     job.pw_end_addr = open_in;
                     job.read_high   = 1'b0;
                     job.read_addr   = cfg_boot_start_word;
                     vi_in    = '0;
                     vh_in    = 1'b0;
                     lo_ok_in = 1'b0;
                     phase_in = ipps_pkg::PH_VERIFY;
                  end
               end
            end
            ipps_pkg::CMD_IMAGE: begin
               if (phase_ff == ipps_pkg::PH_LOAD) begin
                  head_we = seen_ff < ipps_pkg::LEN_W'(ipps_pkg::HEAD_BYTES);
                  seen_in = pos_inc[ipps_pkg::LEN_W-1:0];
                  if (!seen_ff[0] && !last) begin
                     held_in = req_payload_byte;
                  end else begin
                     job_push = 1'b1;
                     if (!seen_ff[0]) begin
                        job.lo = req_payload_byte;
                        job.hi = ipps_pkg::PAD_BYTE;
                     end else begin
                        job.lo = held_ff;
                        job.hi = req_payload_byte;
                     end
                     if (open_ff != cur_page) begin
                        job.mask[ipps_pkg::SLOT_PW_PRE] = 1'b1;
                        job.pw_pre_addr = open_ff;
                        open_in = cur_page;
                     end
                     job.mask[ipps_pkg::SLOT_LOAD_LO] = 1'b1;
                     job.mask[ipps_pkg::SLOT_LOAD_HI] = 1'b1;
                     job.load_addr = wa_ff;
                     wa_in = wa_ff + ipps_pkg::ADDR_W'(1);
                     if (last) begin
                        job.mask[ipps_pkg::SLOT_PW_END] = 1'b1;
                        job.mask[ipps_pkg::SLOT_READ]   = 1'b1;
                        job.pw_end_addr = open_in;
                        job.read_high   = 1'b0;
                        job.read_addr   = cfg_boot_start_word;
                        vi_in    = '0;
                        vh_in    = 1'b0;
                        lo_ok_in = 1'b0;
                        phase_in = ipps_pkg::PH_VERIFY;
                     end
                  end
               end
            end
            ipps_pkg::CMD_REPLY: begin
               if (phase_ff == ipps_pkg::PH_VERIFY) begin
                  job_push = 1'b1;
                  if (!vh_ff) begin
                     lo_ok_in = req_payload_byte == expected;
                     vh_in    = 1'b1;
                     job.mask[ipps_pkg::SLOT_READ] = 1'b1;
                     job.read_high = 1'b1;
                     job.read_addr = cfg_boot_start_word + ipps_pkg::ADDR_W'(vi_ff);
                  end else begin
                     vh_in = 1'b0;
                     if (!lo_ok_ff || req_payload_byte != expected) begin
                        job.mask[ipps_pkg::SLOT_STATUS] = 1'b1;
                        job.status = ipps_pkg::ST_FAIL;
                        phase_in = ipps_pkg::PH_DONE;
                     end else begin
                        vi_in = vi_inc;
                        if (vi_inc == ipps_pkg::VI_W'(ipps_pkg::VERIFY_WORDS)) begin
                           job.mask[ipps_pkg::SLOT_STATUS] = 1'b1;
                           job.status = ipps_pkg::ST_PASS;
                           phase_in = ipps_pkg::PH_DONE;
                        end else begin
                           job.mask[ipps_pkg::SLOT_READ] = 1'b1;
                           job.read_high = 1'b0;
                           job.read_addr = cfg_boot_start_word + ipps_pkg::ADDR_W'(vi_inc);
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ipps_pkg::PH_IDLE;
         wa_ff    <= '0;
         open_ff  <= '0;
         seen_ff  <= '0;
         img_ff   <= '0;
         held_ff  <= '0;
         vi_ff    <= '0;
         vh_ff    <= 1'b0;
         lo_ok_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         wa_ff    <= wa_in;
         open_ff  <= open_in;
         seen_ff  <= seen_in;
         img_ff   <= img_in;
         held_ff  <= held_in;
         vi_ff    <= vi_in;
         vh_ff    <= vh_in;
         lo_ok_ff <= lo_ok_in;
      end
   end

   // A write to the entry being prefetched is forwarded to the read register.
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem_ff[head_waddr] <= req_payload_byte;
      end
      if (head_we && head_waddr == head_raddr) begin
         head_q_ff <= req_payload_byte;
      end else begin
         head_q_ff <= head_mem_ff[head_raddr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ipps_job_queue.sv =====
`default_nettype none

module ipps_job_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ipps_pkg::job_type din,
   output logic              full,
   input  logic              pop,
   output ipps_pkg::job_type dout,
   output logic              empty
);

   ipps_pkg::job_type entry_ff [2];
   logic              wptr_ff, wptr_in;
   logic              rptr_ff, rptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full    = cnt_ff == 2'd2;
   assign empty   = cnt_ff == 2'd0;
   assign dout    = entry_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in = wptr_ff ^ do_push;
      rptr_in = rptr_ff ^ do_pop;
      cnt_in  = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/ipps_back.sv =====
`default_nettype none

module ipps_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_empty,
   input  ipps_pkg::job_type job,
   output logic              job_pop,
   input  logic              cfg_page_write_pause,
   input  logic              rsp_pop,
   output logic              rsp_empty,
   output ipps_pkg::rsp_type rsp
);

   ipps_pkg::job_type            cur_ff;
   logic [ipps_pkg::NSLOTS-1:0]  mask_ff, mask_in;
   ipps_pkg::rsp_type            out_q_ff [2];
   logic                         out_wptr_ff, out_rptr_ff;
   logic [1:0]                   out_cnt_ff, out_cnt_in;

   logic [ipps_pkg::SLOT_W-1:0]  slot;
   logic                         found;
   logic [ipps_pkg::NSLOTS-1:0]  rest;
   logic [ipps_pkg::NSLOTS-1:0]  mask_after;
   logic                         out_pop;
   logic                         out_space;
   logic                         emit;
   logic [1:0]                   pw_wait;
   ipps_pkg::rsp_type            res;

   // Lowest pending slot goes out first.
   always_comb begin
      slot  = '0;
      found = 1'b0;
      for (int i = 0; i < ipps_pkg::NSLOTS; i++) begin
         if (mask_ff[i] && !found) begin
            slot  = ipps_pkg::SLOT_W'(i);
            found = 1'b1;
         end
      end
   end

   assign rest    = mask_ff & ~(ipps_pkg::NSLOTS'(1) << slot);
   assign pw_wait = cfg_page_write_pause ? ipps_pkg::WAIT_PAGE : ipps_pkg::WAIT_NONE;

   always_comb begin
      res = '0;
      res.last_of_run = rest == '0;
      case (slot)
         ipps_pkg::SLOT_ERASE: begin
            res.has_command = 1'b1;
            res.cmd_byte0   = ipps_pkg::OP_ERASE;
            res.cmd_byte1   = ipps_pkg::ERASE_B1;
            res.wait_code   = ipps_pkg::WAIT_ERASE;
         end
         ipps_pkg::SLOT_PW_PRE: begin
            res.has_command = 1'b1;
            res.cmd_byte0   = ipps_pkg::OP_WRITE;
            res.cmd_byte1   = cur_ff.pw_pre_addr[15:8];
            res.cmd_byte2   = cur_ff.pw_pre_addr[7:0];
            res.wait_code   = pw_wait;
         end
         ipps_pkg::SLOT_LOAD_LO: begin
            res.has_command = 1'b1;
            res.cmd_byte0   = ipps_pkg::OP_LOAD_LO;
            res.cmd_byte1   = cur_ff.load_addr[15:8];
            res.cmd_byte2   = cur_ff.load_addr[7:0];
            res.cmd_byte3   = cur_ff.lo;
         end
         ipps_pkg::SLOT_LOAD_HI: begin
            res.has_command = 1'b1;
            res.cmd_byte0   = ipps_pkg::OP_LOAD_HI;
            res.cmd_byte1   = cur_ff.load_addr[15:8];
            res.cmd_byte2   = cur_ff.load_addr[7:0];
            res.cmd_byte3   = cur_ff.hi;
         end
         ipps_pkg::SLOT_PW_END: begin
            res.has_command = 1'b1;
            res.cmd_byte0   = ipps_pkg::OP_WRITE;
            res.cmd_byte1   = cur_ff.pw_end_addr[15:8];
            res.cmd_byte2   = cur_ff.pw_end_addr[7:0];
            res.wait_code   = pw_wait;
         end
         ipps_pkg::SLOT_READ: begin
            res.has_command   = 1'b1;
            res.cmd_byte0     = cur_ff.read_high ? ipps_pkg::OP_READ_HI
                                                 : ipps_pkg::OP_READ_LO;
            res.cmd_byte1     = cur_ff.read_addr[15:8];
            res.cmd_byte2     = cur_ff.read_addr[7:0];
            res.expects_reply = 1'b1;
         end
         ipps_pkg::SLOT_STATUS: begin
            res.run_status = cur_ff.status;
         end
         default: begin
         end
      endcase
   end

   assign out_pop    = rsp_pop && out_cnt_ff != 2'd0;
   assign out_space  = out_cnt_ff != 2'd2 || out_pop;
   assign emit       = mask_ff != '0 && out_space;
   assign mask_after = emit ? rest : mask_ff;
   assign job_pop    = mask_after == '0 && !job_empty;
   assign mask_in    = job_pop ? job.mask : mask_after;
   assign out_cnt_in = out_cnt_ff + {1'b0, emit} - {1'b0, out_pop};
   assign rsp_empty  = out_cnt_ff == 2'd0;
   assign rsp        = out_q_ff[out_rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff     <= '0;
         out_cnt_ff  <= '0;
         out_wptr_ff <= 1'b0;
         out_rptr_ff <= 1'b0;
      end else begin
         mask_ff     <= mask_in;
         out_cnt_ff  <= out_cnt_in;
         out_wptr_ff <= out_wptr_ff ^ emit;
         out_rptr_ff <= out_rptr_ff ^ out_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         cur_ff <= job;
      end
      if (emit) begin
         out_q_ff[out_wptr_ff] <= res;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/isp_page_program_sequencer_top.sv =====
`default_nettype none

// Serial in-system-programming page sequencer. A start request carries the
// image length; the block answers with a chip erase (or a failure status when
// the length exceeds boot_size_bytes), then turns image-byte requests into
// low and high page-load commands, page writes at page changes and at the
// end, and finally low and high read commands whose reply bytes, fed back as
// reply requests, are checked against the stored head of the image. Each
// result is one command or one closing status, and last_of_run marks the final
// result caused by a request. The front stage accepts one request per clock
// while its two-entry job queue has room; the back stage issues one result per
// clock into a two-entry result queue while that queue has room, and a
// request yields zero to five results. Sustained throughput is therefore set
// by the back stage's single result port. No clearing pass follows reset;
// the block is ready once reset falls. Configuration registers sit at byte
// addresses 0, 4 and 8 and should only be written while the block is idle.

module isp_page_program_sequencer_top (
   input  logic                         clock,
   input  logic                         reset,
   // Request queue.
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [1:0]                   req_cmd,
   input  logic [ipps_pkg::LEN_W-1:0]   req_image_length,
   input  logic [ipps_pkg::BYTE_W-1:0]  req_payload_byte,
   // Result queue.
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output logic                         rsp_has_command,
   output logic [ipps_pkg::BYTE_W-1:0]  rsp_cmd_byte0,
   output logic [ipps_pkg::BYTE_W-1:0]  rsp_cmd_byte1,
   output logic [ipps_pkg::BYTE_W-1:0]  rsp_cmd_byte2,
   output logic [ipps_pkg::BYTE_W-1:0]  rsp_cmd_byte3,
   output logic                         rsp_expects_reply,
   output logic [1:0]                   rsp_wait_code,
   output logic [1:0]                   rsp_run_status,
   output logic                         rsp_last_of_run,
   // Configuration port.
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ipps_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [ipps_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [ipps_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);

   logic [ipps_pkg::ADDR_W-1:0] boot_start_ff;
   logic [ipps_pkg::LEN_W-1:0]  boot_size_ff;
   logic                        pw_pause_ff;
   logic                        csr_write;
   logic [1:0]                  csr_index;

   logic                        req_accept;
   logic                        job_push;
   ipps_pkg::job_type           job_in;
   ipps_pkg::job_type           job_out;
   logic                        job_full;
   logic                        job_empty;
   logic                        job_pop;
   ipps_pkg::rsp_type           rsp;

   // The configuration port never stalls; a write lands on the access cycle.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         boot_start_ff <= ipps_pkg::ADDR_W'(126976);
         boot_size_ff  <= ipps_pkg::LEN_W'(8192);
         pw_pause_ff   <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            ipps_pkg::REG_BOOT_START: boot_start_ff <= csr_pwdata[ipps_pkg::ADDR_W-1:0];
            ipps_pkg::REG_BOOT_SIZE:  boot_size_ff  <= csr_pwdata[ipps_pkg::LEN_W-1:0];
            ipps_pkg::REG_PW_PAUSE:   pw_pause_ff   <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         ipps_pkg::REG_BOOT_START: csr_prdata = ipps_pkg::CSR_DW'(boot_start_ff);
         ipps_pkg::REG_BOOT_SIZE:  csr_prdata = ipps_pkg::CSR_DW'(boot_size_ff);
         ipps_pkg::REG_PW_PAUSE:   csr_prdata = ipps_pkg::CSR_DW'(pw_pause_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   // A request is taken whenever the job queue can hold whatever it yields,
   // even while earlier results are still waiting to be popped.
   assign req_full   = job_full;
   assign req_accept = req_push && !req_full;

   ipps_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_accept          (req_accept),
      .req_cmd             (req_cmd),
      .req_image_length    (req_image_length),
      .req_payload_byte    (req_payload_byte),
      .cfg_boot_start_word (boot_start_ff),
      .cfg_boot_size_bytes (boot_size_ff),
      .job_push            (job_push),
      .job                 (job_in)
   );

   ipps_job_queue u_job_queue (
      .clock (clock),
      .reset (reset),
      .push  (job_push),
      .din   (job_in),
      .full  (job_full),
      .pop   (job_pop),
      .dout  (job_out),
      .empty (job_empty)
   );

   ipps_back u_back (
      .clock                (clock),
      .reset                (reset),
      .job_empty            (job_empty),
      .job                  (job_out),
      .job_pop              (job_pop),
      .cfg_page_write_pause (pw_pause_ff),
      .rsp_pop              (rsp_pop),
      .rsp_empty            (rsp_empty),
      .rsp                  (rsp)
   );

   assign rsp_has_command   = rsp.has_command;
   assign rsp_cmd_byte0     = rsp.cmd_byte0;
   assign rsp_cmd_byte1     = rsp.cmd_byte1;
   assign rsp_cmd_byte2     = rsp.cmd_byte2;
   assign rsp_cmd_byte3     = rsp.cmd_byte3;
   assign rsp_expects_reply = rsp.expects_reply;
   assign rsp_wait_code     = rsp.wait_code;
   assign rsp_run_status    = rsp.run_status;
   assign rsp_last_of_run   = rsp.last_of_run;

endmodule

`default_nettype wire

// ===== rtl/core/ipps_checker.sv =====
`default_nettype none

module ipps_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_has_command,
   input logic [7:0] rsp_cmd_byte0,
   input logic       rsp_expects_reply,
   input logic [1:0] rsp_run_status,
   input logic       rsp_last_of_run
);

   // Both queues come out of reset empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // Commands always report a run in progress.
   a_cmd_busy: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_has_command) |-> rsp_run_status == ipps_pkg::ST_BUSY)
      else $error("command result carries a final status");

   // A closing status ends the request's results and is never in progress.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_has_command) |->
         rsp_last_of_run && rsp_run_status != ipps_pkg::ST_BUSY)
      else $error("status result malformed");

   // Only read commands ask for a reply byte.
   a_reply_read: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_has_command) |->
         rsp_expects_reply == (rsp_cmd_byte0 == ipps_pkg::OP_READ_LO ||
                               rsp_cmd_byte0 == ipps_pkg::OP_READ_HI))
      else $error("reply flag disagrees with instruction");

   // A waiting result stays put until it is popped.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         !rsp_empty && $stable(rsp_cmd_byte0) && $stable(rsp_last_of_run))
      else $error("waiting result changed");

endmodule

bind isp_page_program_sequencer_top ipps_checker u_ipps_checker (.*);

`default_nettype wire

// ===== bench/isp_page_program_sequencer_top_test.sv =====
`default_nettype none

module isp_page_program_sequencer_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ipps_pkg::*;

   // Request kind that the block has no use for; it must be ignored.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Cycles allowed for requests that yield no command to drain out of the
   // two-entry job queue and the back stage before the block counts as idle.
   localparam int DRAIN_CYCLES = 16;

   // Chance, in per cent, that either side sits out a cycle.
   localparam int IDLE_PCT = 26;

   localparam int MAX_IMAGE = 300;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] data;
   } request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_push = 1'b0;
   logic              req_full;
   logic [1:0]        req_cmd = 2'd0;
   logic [LEN_W-1:0]  req_image_length = '0;
   logic [BYTE_W-1:0] req_payload_byte = '0;

   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   logic              rsp_has_command;
   logic [BYTE_W-1:0] rsp_cmd_byte0;
   logic [BYTE_W-1:0] rsp_cmd_byte1;
   logic [BYTE_W-1:0] rsp_cmd_byte2;
   logic [BYTE_W-1:0] rsp_cmd_byte3;
   logic              rsp_expects_reply;
   logic [1:0]        rsp_wait_code;
   logic [1:0]        rsp_run_status;
   logic              rsp_last_of_run;

   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   isp_page_program_sequencer_top uut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cmd           (req_cmd),
      .req_image_length  (req_image_length),
      .req_payload_byte  (req_payload_byte),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_has_command   (rsp_has_command),
      .rsp_cmd_byte0     (rsp_cmd_byte0),
      .rsp_cmd_byte1     (rsp_cmd_byte1),
      .rsp_cmd_byte2     (rsp_cmd_byte2),
      .rsp_cmd_byte3     (rsp_cmd_byte3),
      .rsp_expects_reply (rsp_expects_reply),
      .rsp_wait_code     (rsp_wait_code),
      .rsp_run_status    (rsp_run_status),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #10 clock = ~clock;

   // Requests waiting to be offered, and commands the block still owes us.
   request_type       pending_requests[$];
   rsp_type           pending_commands[$];
   int                queued = 0;
   int                faults = 0;
   logic              req_taken = 1'b0;
   // When set, neither side idles; used for one long stretch of the run.
   logic              calm = 1'b0;

   // Register copies, updated at the clock edge on which the block takes a
   // write.
   logic [ADDR_W-1:0] cfg_start = 17'd126976;
   logic [LEN_W-1:0]  cfg_size = 16'd8192;
   logic              cfg_pause = 1'b1;

   // Behavioural copy of the sequencer state.
   phase_type         seq_phase = PH_IDLE;
   logic [ADDR_W-1:0] next_word = '0;
   logic [ADDR_W-1:0] cur_page = '0;
   logic [LEN_W-1:0]  bytes_taken = '0;
   logic [LEN_W-1:0]  run_bytes = '0;
   logic [BYTE_W-1:0] low_byte_held = '0;
   logic [6:0]        check_word = '0;
   logic              check_high = 1'b0;
   logic [BYTE_W-1:0] first_reply = '0;
   logic [BYTE_W-1:0] head_copy [HEAD_BYTES];

   // ------------------------------------------------------------------
   // Command prediction.
   // ------------------------------------------------------------------

   function automatic logic [ADDR_W-1:0] page_base(input logic [ADDR_W-1:0] a);
      return a - (a % FLASH_PAGE_LEN);
   endfunction

   function automatic void emit(input logic has, input logic [7:0] b0,
                                input logic [7:0] b1, input logic [7:0] b2,
                                input logic [7:0] b3, input logic rep,
                                input logic [1:0] wc, input logic [1:0] st);
      rsp_type c;
      c.has_command   = has;
      c.cmd_byte0     = b0;
      c.cmd_byte1     = b1;
      c.cmd_byte2     = b2;
      c.cmd_byte3     = b3;
      c.expects_reply = rep;
      c.wait_code     = wc;
      c.run_status    = st;
      c.last_of_run   = 1'b0;
      pending_commands.push_back(c);
   endfunction

   // Only address bits 15..0 travel in a command.
   function automatic void emit_cmd(input logic [7:0] op, input logic [ADDR_W-1:0] a,
                                    input logic [7:0] data, input logic rep,
                                    input logic [1:0] wc);
      emit(1'b1, op, a[15:8], a[7:0], data, rep, wc, ST_BUSY);
   endfunction

   function automatic void page_write(input logic [ADDR_W-1:0] a);
      emit_cmd(OP_WRITE, a, 8'h00, 1'b0, cfg_pause ? WAIT_PAGE : WAIT_NONE);
   endfunction

   function automatic void read_cmd();
      logic [ADDR_W-1:0] a;
      a = cfg_start + ADDR_W'(check_word);
      emit_cmd(check_high ? OP_READ_HI : OP_READ_LO, a, 8'h00, 1'b1, WAIT_NONE);
   endfunction

   // A run ends with a command-less result carrying the final status.
   function automatic void close_run(input logic [1:0] st);
      emit(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, WAIT_NONE, st);
      seq_phase = PH_DONE;
   endfunction

   // The closing page write always comes first, then the first low read.
   function automatic void begin_check();
      page_write(cur_page);
      check_word  = '0;
      check_high  = 1'b0;
      first_reply = '0;
      seq_phase   = PH_VERIFY;
      read_cmd();
   endfunction

   // What the target should answer for image byte k: bytes past the image,
   // or past the stored head, read back as erased flash.
   function automatic logic [7:0] head_byte(input int k);
      if (k < int'(run_bytes) && k < HEAD_BYTES) return head_copy[k];
      return PAD_BYTE;
   endfunction

   task automatic sequence_request(input request_type r);
      int                prior_count;
      int                pos;
      int                k;
      logic              last;
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      rsp_type           tail;
      prior_count = pending_commands.size();
      case (r.cmd)
         CMD_START: begin
            if (r.len > cfg_size) begin
               close_run(ST_FAIL);
            end else begin
               emit(1'b1, OP_ERASE, ERASE_B1, 8'h00, 8'h00, 1'b0, WAIT_ERASE, ST_BUSY);
               run_bytes     = r.len;
               bytes_taken   = '0;
               low_byte_held = '0;
               next_word     = cfg_start;
               cur_page      = page_base(cfg_start);
               seq_phase     = PH_LOAD;
               if (r.len == 0) begin_check();
            end
         end
         CMD_IMAGE: begin
            if (seq_phase == PH_LOAD) begin
               pos = int'(bytes_taken);
               if (pos < HEAD_BYTES) head_copy[pos] = r.data;
               bytes_taken = LEN_W'(pos + 1);
               last = (pos + 1 >= int'(run_bytes));
               if (pos % 2 == 0 && !last) begin
                  low_byte_held = r.data;
               end else begin
                  // A lone final byte is paired with the erased value.
                  if (pos % 2 == 0) begin
                     lo = r.data;
                     hi = PAD_BYTE;
                  end else begin
                     lo = low_byte_held;
                     hi = r.data;
                  end
                  if (cur_page != page_base(next_word)) begin
                     page_write(cur_page);
                     cur_page = page_base(next_word);
                  end
                  emit_cmd(OP_LOAD_LO, next_word, lo, 1'b0, WAIT_NONE);
                  emit_cmd(OP_LOAD_HI, next_word, hi, 1'b0, WAIT_NONE);
                  next_word = next_word + 1'b1;
                  if (last) begin_check();
               end
            end
         end
         CMD_REPLY: begin
            if (seq_phase == PH_VERIFY) begin
               if (!check_high) begin
                  first_reply = r.data;
                  check_high  = 1'b1;
                  read_cmd();
               end else begin
                  k = 2 * int'(check_word);
                  check_high = 1'b0;
                  if (first_reply != head_byte(k) || r.data != head_byte(k + 1)) begin
                     close_run(ST_FAIL);
                  end else begin
                     check_word = check_word + 1'b1;
                     if (check_word >= VERIFY_WORDS) close_run(ST_PASS);
                     else read_cmd();
                  end
               end
            end
         end
         default: ;
      endcase
      // Mark the final command this request caused.
      if (pending_commands.size() > prior_count) begin
         tail = pending_commands.pop_back();
         tail.last_of_run = 1'b1;
         pending_commands.push_back(tail);
      end
   endtask

   // ------------------------------------------------------------------
   // Request driver.
   // ------------------------------------------------------------------

   // A request is taken at a rising edge with push high and full low; the
   // bench predicts from what actually sat on the ports at that edge.
   always @(posedge clock) begin
      request_type r;
      req_taken = 1'b0;
      if (!reset && req_push && !req_full) begin
         req_taken = 1'b1;
         r.cmd  = req_cmd;
         r.len  = req_image_length;
         r.data = req_payload_byte;
         void'(pending_requests.pop_front());
         sequence_request(r);
      end
   end

   // A request that is being refused is held as it stands; otherwise the
   // next one is offered unless this cycle is picked as an idle one. Each
   // signal gets at most one assignment per falling edge.
   always @(negedge clock) begin
      if (reset || pending_requests.size() == 0) begin
         req_push <= 1'b0;
      end else if (req_push && !req_taken) begin
         req_push <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_push <= 1'b0;
      end else begin
         req_push         <= 1'b1;
         req_cmd          <= pending_requests[0].cmd;
         req_image_length <= pending_requests[0].len;
         req_payload_byte <= pending_requests[0].data;
      end
   end

   // ------------------------------------------------------------------
   // Result monitor.
   // ------------------------------------------------------------------

   always @(negedge clock) begin
      rsp_pop <= !reset && (calm || $urandom_range(0, 99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.has_command   = rsp_has_command;
         got.cmd_byte0     = rsp_cmd_byte0;
         got.cmd_byte1     = rsp_cmd_byte1;
         got.cmd_byte2     = rsp_cmd_byte2;
         got.cmd_byte3     = rsp_cmd_byte3;
         got.expects_reply = rsp_expects_reply;
         got.wait_code     = rsp_wait_code;
         got.run_status    = rsp_run_status;
         got.last_of_run   = rsp_last_of_run;
         if (pending_commands.size() == 0) begin
            if (faults < 10)
               $display("%0t: result with nothing expected: has=%0d op=%02h %02h %02h %02h",
                        $realtime, got.has_command, got.cmd_byte0, got.cmd_byte1,
                        got.cmd_byte2, got.cmd_byte3);
            faults++;
         end else begin
            want = pending_commands.pop_front();
            if (got !== want) begin
               if (faults < 10) begin
                  $display("%0t: mismatch, expected has=%0d op=%02h %02h %02h %02h rep=%0d wait=%0d st=%0d last=%0d",
                           $realtime, want.has_command, want.cmd_byte0, want.cmd_byte1,
                           want.cmd_byte2, want.cmd_byte3, want.expects_reply,
                           want.wait_code, want.run_status, want.last_of_run);
                  $display("%0t: mismatch, actual   has=%0d op=%02h %02h %02h %02h rep=%0d wait=%0d st=%0d last=%0d",
                           $realtime, got.has_command, got.cmd_byte0, got.cmd_byte1,
                           got.cmd_byte2, got.cmd_byte3, got.expects_reply,
                           got.wait_code, got.run_status, got.last_of_run);
               end
               faults++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------

   function automatic void add_req(input logic [1:0] cmd, input logic [LEN_W-1:0] len,
                                   input logic [BYTE_W-1:0] data);
      request_type r;
      r.cmd  = cmd;
      r.len  = len;
      r.data = data;
      pending_requests.push_back(r);
      queued++;
   endfunction

   // Writes one register over the configuration port, then reads it back.
   // The bench copy changes at the very edge the block takes the write.
   task automatic csr_write(input logic [1:0] idx, input logic [CSR_DW-1:0] val);
      logic [CSR_DW-1:0] kept;
      case (idx)
         REG_BOOT_START: kept = CSR_DW'(val[ADDR_W-1:0]);
         REG_BOOT_SIZE:  kept = CSR_DW'(val[LEN_W-1:0]);
         default:        kept = CSR_DW'(val[0]);
      endcase
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         REG_BOOT_START: cfg_start = kept[ADDR_W-1:0];
         REG_BOOT_SIZE:  cfg_size  = kept[LEN_W-1:0];
         default:        cfg_pause = kept[0];
      endcase
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== kept) begin
         if (faults < 10)
            $display("%0t: register %0d reads %08h, expected %08h",
                     $realtime, idx, csr_prdata, kept);
         faults++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Waits until every request has gone in and every command has come out,
   // then lets requests without commands drain.
   task automatic settle();
      while (pending_requests.size() != 0 || pending_commands.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Queues one programming run. Most runs are well formed: a start, the
   // image bytes, and reply bytes that match the image up to a chosen word,
   // where one byte is spoiled or the run is left hanging. A few are cut short
   // by the next start, some are rejected for length, and some are stray
   // requests only. With full_pass set, the whole head is answered correctly.
   task automatic add_run(input logic full_pass);
      int                kind;
      int                n;
      int                cap;
      int                stop_word;
      int                how;
      logic [BYTE_W-1:0] img [MAX_IMAGE];
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      kind = full_pass ? 99 : $urandom_range(0, 99);
      if (kind < 10) begin
         if (cfg_size != 16'hFFFF) begin
            add_req(CMD_START, LEN_W'($urandom_range(int'(cfg_size) + 1, 65535)),
                    BYTE_W'($urandom));
         end else begin
            // Every length fits: start a huge image and abandon it.
            add_req(CMD_START, 16'hFFFF, BYTE_W'($urandom));
            repeat ($urandom_range(1, 5))
               add_req(CMD_IMAGE, LEN_W'($urandom), BYTE_W'($urandom));
         end
         return;
      end
      if (kind < 16) begin
         repeat ($urandom_range(1, 3))
            add_req(2'($urandom_range(1, 3)), LEN_W'($urandom), BYTE_W'($urandom));
         return;
      end
      cap = (int'(cfg_size) < MAX_IMAGE) ? int'(cfg_size) : MAX_IMAGE;
      if (full_pass || $urandom_range(0, 99) < 95)
         n = $urandom_range(0, (cap < 24) ? cap : 24);
      else n = $urandom_range(0, cap);
      add_req(CMD_START, LEN_W'(n), BYTE_W'($urandom));
      for (int k = 0; k < n; k++) begin
         img[k] = BYTE_W'($urandom);
         if (!full_pass && $urandom_range(0, 99) < 3)
            add_req($urandom_range(0, 1) ? CMD_REPLY : CMD_UNUSED, LEN_W'($urandom),
                    BYTE_W'($urandom));
         if (!full_pass && $urandom_range(0, 99) < 2) return;
         add_req(CMD_IMAGE, LEN_W'($urandom), img[k]);
      end
      if (full_pass) stop_word = VERIFY_WORDS;
      else if ($urandom_range(0, 99) < 80) stop_word = $urandom_range(0, 6);
      else stop_word = $urandom_range(0, VERIFY_WORDS - 1);
      how = $urandom_range(0, 2);
      for (int w = 0; w < VERIFY_WORDS && w <= stop_word; w++) begin
         lo = (2 * w < n && 2 * w < HEAD_BYTES) ? img[2 * w] : PAD_BYTE;
         hi = (2 * w + 1 < n && 2 * w + 1 < HEAD_BYTES) ? img[2 * w + 1] : PAD_BYTE;
         if (w == stop_word) begin
            // Either leave the run hanging in verification or spoil a byte.
            if (how == 2) return;
            if (how == 0) lo = lo ^ BYTE_W'($urandom_range(1, 255));
            else hi = hi ^ BYTE_W'($urandom_range(1, 255));
         end
         add_req(CMD_REPLY, LEN_W'($urandom), lo);
         if (!full_pass && $urandom_range(0, 99) < 3)
            add_req(CMD_IMAGE, LEN_W'($urandom), BYTE_W'($urandom));
         add_req(CMD_REPLY, LEN_W'($urandom), hi);
      end
   endtask

   initial begin
      int target;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed requests at the reset register values: strays while idle,
      // over-long images, an empty image, an odd-length image with strays
      // during loading and verification, and mismatches on the high byte.
      add_req(CMD_UNUSED, 16'hFFFF, 8'hFF);
      add_req(CMD_IMAGE, 16'h0000, 8'h3C);
      add_req(CMD_REPLY, 16'h1234, 8'hC3);
      add_req(CMD_START, 16'd8193, 8'h00);
      add_req(CMD_START, 16'hFFFF, 8'hFF);
      add_req(CMD_START, 16'd8192, 8'h00);
      add_req(CMD_START, 16'd0, 8'h00);
      add_req(CMD_REPLY, 16'h0000, 8'hFF);
      add_req(CMD_REPLY, 16'h0000, 8'h00);
      add_req(CMD_START, 16'd3, 8'hAA);
      add_req(CMD_IMAGE, 16'h0000, 8'h00);
      add_req(CMD_REPLY, 16'h0000, 8'h55);
      add_req(CMD_IMAGE, 16'hFFFF, 8'hFF);
      add_req(CMD_IMAGE, 16'h0000, 8'hA5);
      add_req(CMD_IMAGE, 16'h0000, 8'h11);
      add_req(CMD_REPLY, 16'h0000, 8'h00);
      add_req(CMD_REPLY, 16'h0000, 8'hFF);
      add_req(CMD_REPLY, 16'h0000, 8'hA5);
      add_req(CMD_REPLY, 16'h0000, 8'hFF);
      add_req(CMD_REPLY, 16'h0000, 8'hFF);
      add_req(CMD_REPLY, 16'h0000, 8'hFE);
      add_req(CMD_START, 16'd1, 8'h00);
      add_req(CMD_IMAGE, 16'h0000, 8'h5A);
      add_req(CMD_REPLY, 16'h0000, 8'h5A);
      add_req(CMD_REPLY, 16'h0000, 8'h00);

      // Random runs at the reset values, opening with a full verified pass.
      add_run(1'b1);
      target = queued + 20;
      while (queued < target) add_run(1'b0);
      settle();

      // Top of the address space with an empty-only boot area and no page
      // settle wait: reads wrap from the last word to word zero. This whole
      // stretch runs with neither side idling.
      calm = 1'b1;
      csr_write(REG_BOOT_START, 32'h0001_FFFF);
      csr_write(REG_BOOT_SIZE, 32'h0000_0000);
      csr_write(REG_PW_PAUSE, 32'h0000_0000);
      target = queued + 25;
      while (queued < target) add_run(1'b0);
      settle();
      calm = 1'b0;

      // Bottom of the address space with the largest boot area; longer
      // images cross a page boundary.
      csr_write(REG_BOOT_START, 32'h0000_0000);
      csr_write(REG_BOOT_SIZE, 32'h0000_FFFF);
      csr_write(REG_PW_PAUSE, 32'h0000_0001);
      target = queued + 15;
      while (queued < target) add_run(1'b0);
      settle();

      // Random settings, the start word a few words short of a page end so
      // that even small images change page.
      repeat (2) begin
         csr_write(REG_BOOT_START,
                   CSR_DW'(ADDR_W'($urandom_range(0, 1023) * FLASH_PAGE_LEN + FLASH_PAGE_LEN
                                   - $urandom_range(1, 4))));
         csr_write(REG_BOOT_SIZE, CSR_DW'($urandom_range(1, 400)));
         csr_write(REG_PW_PAUSE, CSR_DW'($urandom_range(0, 1)));
         target = queued + 10;
         while (queued < target) add_run(1'b0);
         settle();
      end

      if (faults == 0) begin
         $display("isp_page_program_sequencer_top_test: done, clean");
      end else begin
         $display("isp_page_program_sequencer_top_test: done, errors");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("isp_page_program_sequencer_top_test: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

// ===== isp_page_program_sequencer_top.f =====
rtl/core/ipps_pkg.sv
rtl/core/ipps_front.sv
rtl/core/ipps_job_queue.sv
rtl/core/ipps_back.sv
rtl/core/isp_page_program_sequencer_top.sv
rtl/core/ipps_checker.sv
bench/isp_page_program_sequencer_top_test.sv
